// ----- rtl/fjr_pkg.sv -----
// Shared types, codes and reset values for the feeder jam recovery controller.
package fjr_pkg;

  localparam int MEAS_W      = 32;
  localparam int SPEED_W     = 16;
  localparam int CMD_W       = 2;
  localparam int MODE_W      = 3;
  localparam int SEL_W       = 2;
  localparam int STEP_W      = 20;
  localparam int COUNT_W     = 8;
  localparam int LIMIT_W     = 16;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 3;

  localparam int ANGLE_BITS_DEFAULT = 32;
  localparam int TICK_BITS_DEFAULT  = 16;

  // Speed magnitude at or below this counts as stalled.
  localparam int STALL_SPEED = 2;

  localparam logic [MODE_W-1:0] MODE_HOLD   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RELOAD = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FJAM   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UNLOAD = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BJAM   = 3'd4;

  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELOAD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNLOAD = 2'd2;

  localparam logic [SEL_W-1:0] SEL_NONE = 2'd0;
  localparam logic [SEL_W-1:0] SEL_HOLD = 2'd1;
  localparam logic [SEL_W-1:0] SEL_FWD  = 2'd2;
  localparam logic [SEL_W-1:0] SEL_BWD  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_RELOAD_STEP      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UNLOAD_STEP      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCK_BACKOFF     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ARRIVE_TOLERANCE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RELOAD_MAX_STEPS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_UNLOAD_MAX_STEPS = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_JAM_RETRY_LIMIT  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_STALL_TICK_LIMIT = 3'd7;

  localparam logic [STEP_W-1:0]  RST_RELOAD_STEP      = 20'd36864;
  localparam logic [STEP_W-1:0]  RST_UNLOAD_STEP      = 20'd36864;
  localparam logic [STEP_W-1:0]  RST_LOCK_BACKOFF     = 20'd8192;
  localparam logic [STEP_W-1:0]  RST_ARRIVE_TOLERANCE = 20'd2048;
  localparam logic [COUNT_W-1:0] RST_RELOAD_MAX_STEPS = 8'd4;
  localparam logic [COUNT_W-1:0] RST_UNLOAD_MAX_STEPS = 8'd4;
  localparam logic [COUNT_W-1:0] RST_JAM_RETRY_LIMIT  = 8'd3;
  localparam logic [LIMIT_W-1:0] RST_STALL_TICK_LIMIT = 16'd100;

  typedef struct packed {
    logic [STEP_W-1:0]  reload_step;
    logic [STEP_W-1:0]  unload_step;
    logic [STEP_W-1:0]  lock_backoff;
    logic [STEP_W-1:0]  arrive_tolerance;
    logic [COUNT_W-1:0] reload_max_steps;
    logic [COUNT_W-1:0] unload_max_steps;
    logic [COUNT_W-1:0] jam_retry_limit;
    logic [LIMIT_W-1:0] stall_tick_limit;
  } fjr_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CMD_W-1:0]   pending;
    logic [COUNT_W-1:0] step_count;
    logic [COUNT_W-1:0] jam_count;
  } fjr_ctrl_t;

endpackage

// ----- rtl/fjr_channels.sv -----
// Valid/ready channel interfaces for tick words and result words.
interface fjr_tick_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fjr_pkg::MEAS_W-1:0]    measured_angle;
  logic signed [fjr_pkg::SPEED_W-1:0]   measured_speed;
  logic        [fjr_pkg::CMD_W-1:0]     command;

  modport source (output valid, measured_angle, measured_speed, command, input ready);
  modport sink   (input valid, measured_angle, measured_speed, command, output ready);
endinterface

interface fjr_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fjr_pkg::MEAS_W-1:0]    target_angle;
  logic        [fjr_pkg::MODE_W-1:0]    mode;
  logic        [fjr_pkg::SEL_W-1:0]     drive_limit_select;
  logic                                 clear_ready;

  modport source (output valid, target_angle, mode, drive_limit_select, clear_ready,
                  input ready);
  modport sink   (input valid, target_angle, mode, drive_limit_select, clear_ready,
                  output ready);
endinterface

// ----- rtl/fjr_cfg_regs.sv -----
// Configuration register file for the feeder jam recovery controller.
module fjr_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fjr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fjr_pkg::CFG_DATA_W-1:0]      cfg_data,
  output fjr_pkg::fjr_cfg_t                   cfg
);
  import fjr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reload_step      <= RST_RELOAD_STEP;
      cfg.unload_step      <= RST_UNLOAD_STEP;
      cfg.lock_backoff     <= RST_LOCK_BACKOFF;
      cfg.arrive_tolerance <= RST_ARRIVE_TOLERANCE;
      cfg.reload_max_steps <= RST_RELOAD_MAX_STEPS;
      cfg.unload_max_steps <= RST_UNLOAD_MAX_STEPS;
      cfg.jam_retry_limit  <= RST_JAM_RETRY_LIMIT;
      cfg.stall_tick_limit <= RST_STALL_TICK_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RELOAD_STEP:      cfg.reload_step      <= cfg_data;
        REG_UNLOAD_STEP:      cfg.unload_step      <= cfg_data;
        REG_LOCK_BACKOFF:     cfg.lock_backoff     <= cfg_data;
        REG_ARRIVE_TOLERANCE: cfg.arrive_tolerance <= cfg_data;
        REG_RELOAD_MAX_STEPS: cfg.reload_max_steps <= cfg_data[COUNT_W-1:0];
        REG_UNLOAD_MAX_STEPS: cfg.unload_max_steps <= cfg_data[COUNT_W-1:0];
        REG_JAM_RETRY_LIMIT:  cfg.jam_retry_limit  <= cfg_data[COUNT_W-1:0];
        REG_STALL_TICK_LIMIT: cfg.stall_tick_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/fjr_step.sv -----
// Next-state and result logic for one control tick.
module fjr_step #(
  parameter int ANGLE_BITS = fjr_pkg::ANGLE_BITS_DEFAULT,
  parameter int TICK_BITS  = fjr_pkg::TICK_BITS_DEFAULT
) (
  input  fjr_pkg::fjr_cfg_t                   cfg,
  input  fjr_pkg::fjr_ctrl_t                  ctrl,
  input  logic [ANGLE_BITS-1:0]               target_q,
  input  logic [ANGLE_BITS-1:0]               resume_q,
  input  logic [TICK_BITS-1:0]                stall_q,
  input  logic [ANGLE_BITS-1:0]               meas,
  input  logic signed [fjr_pkg::SPEED_W-1:0]  speed,
  input  logic [fjr_pkg::CMD_W-1:0]           command,
  output fjr_pkg::fjr_ctrl_t                  ctrl_next,
  output logic [ANGLE_BITS-1:0]               target_next,
  output logic [ANGLE_BITS-1:0]               resume_next,
  output logic [TICK_BITS-1:0]                stall_next,
  output logic [fjr_pkg::SEL_W-1:0]           sel,
  output logic                                clr
);
  import fjr_pkg::*;

  localparam int CMP_W = (TICK_BITS > LIMIT_W) ? TICK_BITS : LIMIT_W;

  logic [63:0]           rstep_w, ustep_w, lock_w, tol_w;
  logic [ANGLE_BITS-1:0] rstep, ustep, lock, tol;
  logic                  stalled;
  logic                  near_fwd;  // target minus tolerance below measured angle
  logic                  near_bwd;  // measured angle below target plus tolerance
  logic [TICK_BITS-1:0]  stall_inc;
  logic                  stall_hit;
  logic [COUNT_W-1:0]    jam_inc;
  logic                  jam_out;

  assign rstep_w = 64'(cfg.reload_step);
  assign ustep_w = 64'(cfg.unload_step);
  assign lock_w  = 64'(cfg.lock_backoff);
  assign tol_w   = 64'(cfg.arrive_tolerance);
  assign rstep   = rstep_w[ANGLE_BITS-1:0];
  assign ustep   = ustep_w[ANGLE_BITS-1:0];
  assign lock    = lock_w[ANGLE_BITS-1:0];
  assign tol     = tol_w[ANGLE_BITS-1:0];

  assign stalled  = (speed <= SPEED_W'(STALL_SPEED)) && (speed >= -SPEED_W'(STALL_SPEED));
  assign near_fwd = $signed(target_q - tol) < $signed(meas);
  assign near_bwd = $signed(meas) < $signed(target_q + tol);

  // Saturating stall and jam counters.
  assign stall_inc = (stall_q != {TICK_BITS{1'b1}}) ? stall_q + 1'b1 : stall_q;
  assign stall_hit = CMP_W'(stall_inc) >= CMP_W'(cfg.stall_tick_limit);
  assign jam_inc   = (ctrl.jam_count != {COUNT_W{1'b1}}) ? ctrl.jam_count + 1'b1
                                                         : ctrl.jam_count;
  assign jam_out   = jam_inc >= cfg.jam_retry_limit;

  always_comb begin
    ctrl_next   = ctrl;
    target_next = target_q;
    resume_next = resume_q;
    stall_next  = stall_q;
    sel         = SEL_NONE;
    clr         = 1'b0;

    if (command == CMD_RELOAD || command == CMD_UNLOAD) begin
      ctrl_next.pending = command;
    end

    case (ctrl.mode)
      MODE_RELOAD: begin
        if (near_fwd) begin
          if (ctrl.step_count >= cfg.reload_max_steps) begin
            target_next          = meas;
            ctrl_next.mode       = MODE_HOLD;
            ctrl_next.step_count = '0;
            ctrl_next.jam_count  = '0;
            resume_next          = '0;
          end else begin
            target_next          = target_q + rstep;
            ctrl_next.step_count = ctrl.step_count + 1'b1;
            stall_next           = '0;
          end
        end else if (stalled) begin
          stall_next = stall_inc;
          if (stall_hit) begin
            ctrl_next.jam_count = jam_inc;
            if (jam_out) begin
              target_next          = meas;
              ctrl_next.mode       = MODE_HOLD;
              ctrl_next.step_count = '0;
              ctrl_next.jam_count  = '0;
              resume_next          = '0;
            end else begin
              ctrl_next.mode = MODE_FJAM;
              resume_next    = target_q - meas + lock;
              target_next    = meas - lock;
              stall_next     = '0;
            end
          end
        end else begin
          stall_next = '0;
        end
        if (ctrl_next.pending == CMD_UNLOAD) begin
          ctrl_next.mode       = MODE_UNLOAD;
          ctrl_next.pending    = CMD_NONE;
          target_next          = meas - ustep;
          sel                  = SEL_BWD;
          ctrl_next.step_count = 8'd1;
          stall_next           = '0;
        end
      end
      MODE_FJAM: begin
        if (near_bwd || (stalled && stall_hit)) begin
          ctrl_next.mode = MODE_RELOAD;
          target_next    = target_q + resume_q;
          stall_next     = '0;
        end else if (stalled) begin
          stall_next = stall_inc;
        end else begin
          stall_next = '0;
        end
      end
      MODE_UNLOAD: begin
        clr = 1'b1;
        if (near_bwd) begin
          if (ctrl.step_count >= cfg.unload_max_steps) begin
            target_next          = meas;
            ctrl_next.mode       = MODE_HOLD;
            ctrl_next.step_count = '0;
            ctrl_next.jam_count  = '0;
            resume_next          = '0;
          end else begin
            target_next          = target_q - ustep;
            ctrl_next.step_count = ctrl.step_count + 1'b1;
            stall_next           = '0;
          end
        end else if (stalled) begin
          stall_next = stall_inc;
          if (stall_hit) begin
            ctrl_next.jam_count = jam_inc;
            if (jam_out) begin
              target_next          = meas;
              ctrl_next.mode       = MODE_HOLD;
              ctrl_next.step_count = '0;
              ctrl_next.jam_count  = '0;
              resume_next          = '0;
            end else begin
              ctrl_next.mode = MODE_BJAM;
              resume_next    = target_q - meas - lock;
              target_next    = meas + lock;
              stall_next     = '0;
            end
          end
        end
        // A moving feeder leaves the stall count alone while unloading.
        if (ctrl_next.pending == CMD_RELOAD) begin
          ctrl_next.mode       = MODE_RELOAD;
          target_next          = meas + rstep;
          stall_next           = '0;
          ctrl_next.step_count = 8'd1;
          ctrl_next.jam_count  = '0;
          ctrl_next.pending    = CMD_NONE;
          sel                  = SEL_FWD;
        end
      end
      MODE_BJAM: begin
        if (near_fwd || (stalled && stall_hit)) begin
          ctrl_next.mode = MODE_UNLOAD;
          target_next    = target_q - resume_q;
          stall_next     = '0;
        end else if (stalled) begin
          stall_next = stall_inc;
        end else begin
          stall_next = '0;
        end
      end
      MODE_HOLD: begin
        sel         = SEL_HOLD;
        target_next = meas;
        if (ctrl_next.pending == CMD_RELOAD) begin
          ctrl_next.mode       = MODE_RELOAD;
          target_next          = meas + rstep;
          stall_next           = '0;
          ctrl_next.step_count = 8'd1;
          ctrl_next.jam_count  = '0;
          ctrl_next.pending    = CMD_NONE;
          sel                  = SEL_FWD;
        end else if (ctrl_next.pending == CMD_UNLOAD) begin
          ctrl_next.mode       = MODE_UNLOAD;
          target_next          = meas - ustep;
          stall_next           = '0;
          ctrl_next.step_count = 8'd1;
          ctrl_next.jam_count  = '0;
          ctrl_next.pending    = CMD_NONE;
          sel                  = SEL_BWD;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/feeder_jam_recovery_controller.sv -----
// Feeder jam recovery controller: one tick word per cycle while result.ready is high. The
// step logic between the input register and the result register evaluates a whole tick,
// and the state registers update as it fires. A tick word is taken while a finished result
// still waits on the output register. Reset (rst, synchronous): mode hold, no pending
// command, target, counters and resume offset zero, configuration registers at their
// documented defaults.
module feeder_jam_recovery_controller #(
  parameter int ANGLE_BITS = fjr_pkg::ANGLE_BITS_DEFAULT,
  parameter int TICK_BITS  = fjr_pkg::TICK_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fjr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fjr_pkg::CFG_DATA_W-1:0]     cfg_data,
  fjr_tick_if.sink                           tick,
  fjr_result_if.source                       result
);
  import fjr_pkg::*;

  fjr_cfg_t cfg;

  // Input register: holds one tick word until the step logic fires on it.
  logic                      in_valid;
  logic [ANGLE_BITS-1:0]     meas_q;
  logic signed [SPEED_W-1:0] speed_q;
  logic [CMD_W-1:0]          cmd_q;
  logic [63:0]               meas_ext;

  // Controller state.
  fjr_ctrl_t             ctrl;
  logic [ANGLE_BITS-1:0] target_reg;
  logic [ANGLE_BITS-1:0] resume_offset;
  logic [TICK_BITS-1:0]  stall_ticks;

  fjr_ctrl_t             ctrl_next;
  logic [ANGLE_BITS-1:0] target_reg_next;
  logic [ANGLE_BITS-1:0] resume_offset_next;
  logic [TICK_BITS-1:0]  stall_ticks_next;
  logic [SEL_W-1:0]      sel_next;
  logic                  clr_next;
  logic [63:0]           target_wide;

  // Result register.
  logic                  out_valid;
  logic [MEAS_W-1:0]     target_out;
  logic [MODE_W-1:0]     mode_out;
  logic [SEL_W-1:0]      sel_out;
  logic                  clr_out;

  logic fire;
  logic accept;

  fjr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Fire when a tick word waits and the result register is free or being drained.
  assign fire       = in_valid && (!out_valid || result.ready);
  assign tick.ready = !in_valid || fire;
  assign accept     = tick.valid && tick.ready;

  // Sign-extend the measured angle, then wrap to the internal angle width.
  assign meas_ext = 64'(tick.measured_angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept || (in_valid && !fire);
    end
    if (accept) begin
      meas_q  <= meas_ext[ANGLE_BITS-1:0];
      speed_q <= tick.measured_speed;
      cmd_q   <= tick.command;
    end
  end

  fjr_step #(
    .ANGLE_BITS (ANGLE_BITS),
    .TICK_BITS  (TICK_BITS)
  ) u_step (
    .cfg         (cfg),
    .ctrl        (ctrl),
    .target_q    (target_reg),
    .resume_q    (resume_offset),
    .stall_q     (stall_ticks),
    .meas        (meas_q),
    .speed       (speed_q),
    .command     (cmd_q),
    .ctrl_next   (ctrl_next),
    .target_next (target_reg_next),
    .resume_next (resume_offset_next),
    .stall_next  (stall_ticks_next),
    .sel         (sel_next),
    .clr         (clr_next)
  );

  // Zero-extend or truncate the wrapped target onto the 32-bit result field.
  assign target_wide = 64'(target_reg_next);

  // Advance state and load the result register together.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.mode       <= MODE_HOLD;
      ctrl.pending    <= CMD_NONE;
      ctrl.step_count <= '0;
      ctrl.jam_count  <= '0;
      target_reg      <= '0;
      resume_offset   <= '0;
      stall_ticks     <= '0;
      out_valid       <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && !result.ready);
      if (fire) begin
        ctrl          <= ctrl_next;
        target_reg    <= target_reg_next;
        resume_offset <= resume_offset_next;
        stall_ticks   <= stall_ticks_next;
      end
    end
    if (fire) begin
      target_out <= target_wide[MEAS_W-1:0];
      mode_out   <= ctrl_next.mode;
      sel_out    <= sel_next;
      clr_out    <= clr_next;
    end
  end

  assign result.valid              = out_valid;
  assign result.target_angle       = $signed(target_out);
  assign result.mode               = mode_out;
  assign result.drive_limit_select = sel_out;
  assign result.clear_ready        = clr_out;

  // A fired tick always leaves a word in the result register.
  a_fire_loads: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("fired tick did not produce a result word");

  // Forward drive limit only accompanies entry into reload.
  a_fwd_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sel_out == SEL_FWD) |-> mode_out == MODE_RELOAD)
    else $error("forward limit reported outside reload");

  // Backward drive limit only accompanies entry into unload.
  a_bwd_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sel_out == SEL_BWD) |-> mode_out == MODE_UNLOAD)
    else $error("backward limit reported outside unload");

  // A forward jam resolves only back into reload, or stays put.
  a_fjam_exit: assert property (@(posedge clk) disable iff (rst)
    (fire && ctrl.mode == MODE_FJAM) |=> (ctrl.mode == MODE_FJAM || ctrl.mode == MODE_RELOAD))
    else $error("forward jam left to an unexpected mode");

endmodule
